// File: rtl/rk4pla_pkg.sv
`timescale 1ns / 1ps

package rk4pla_pkg;

   // word and arithmetic widths
   localparam int WORD_W        = 32;
   localparam int STEP_W        = 25;
   localparam int MUL_A_W       = WORD_W + 1;
   localparam int PROD_W        = MUL_A_W + WORD_W;
   localparam int SUM_W         = 35;
   localparam int CNT_W         = 32;
   localparam int LANES         = 3;
   localparam int FRAC_BITS_DEF = 24;

   // divide-by-six unit: one 4-bit digit per cycle
   localparam int DIV_W      = 36;
   localparam int DIV_DIGIT  = 4;
   localparam int DIV_ITER   = DIV_W / DIV_DIGIT;
   localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);
   localparam logic [3:0] MEAN_DIVISOR = 4'd6;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A3   = 3'd6;

   // register reset values
   localparam logic [STEP_W-1:0]        STEP_SIZE_RST = 25'd8389;
   localparam logic signed [WORD_W-1:0] COEF_C1_RST   = -32'sd45130301;
   localparam logic signed [WORD_W-1:0] COEF_C2_RST   = -32'sd39980106;
   localparam logic signed [WORD_W-1:0] COEF_C3_RST   = -32'sd235703108;
   localparam logic signed [WORD_W-1:0] COEF_A1_RST   = 32'sd3187671;
   localparam logic signed [WORD_W-1:0] COEF_A2_RST   = -32'sd32957163;
   localparam logic signed [WORD_W-1:0] COEF_A3_RST   = 32'sd105901143;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // saturation bounds on the wide form
   localparam logic signed [PROD_W-1:0] CLIP_MAX = PROD_W'({1'b0, {(WORD_W-1){1'b1}}});
   localparam logic signed [PROD_W-1:0] CLIP_MIN = ~CLIP_MAX;

   typedef struct packed {
      logic                     command;
      logic signed [WORD_W-1:0] x_init;
      logic signed [WORD_W-1:0] y_init;
      logic signed [WORD_W-1:0] z_init;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] x_out;
      logic signed [WORD_W-1:0] y_out;
      logic signed [WORD_W-1:0] z_out;
      logic [CNT_W-1:0]         step_count;
      logic                     saturated;
   } rsp_item_type;

   // multiplier operations of one slope evaluation, in issue order
   typedef enum logic [3:0] {
      MUL_C1D,
      MUL_C2D,
      MUL_C3D,
      MUL_A3X,
      MUL_A2Y,
      MUL_A1Z,
      MUL_HFX,
      MUL_HFY,
      MUL_HFZ
   } mul_op_type;

   typedef struct packed {
      logic       start;
      logic       load;
      logic       setup;
      logic [1:0] stage;
      logic       diff;
      logic       mul_en;
      mul_op_type mul_op;
      logic       wb_en;
      mul_op_type wb_op;
      logic       acc_last;
      logic       div_start;
      logic       div_run;
      logic       advance;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     hit;
   } clip_type;

   // saturate a wide value to one word
   function automatic clip_type clip32(input logic signed [PROD_W-1:0] v);
      clip_type r;
      if (v > CLIP_MAX) begin
         r.value = CLIP_MAX[WORD_W-1:0];
         r.hit   = 1'b1;
      end else if (v < CLIP_MIN) begin
         r.value = CLIP_MIN[WORD_W-1:0];
         r.hit   = 1'b1;
      end else begin
         r.value = v[WORD_W-1:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   // exact add, then saturate
   function automatic clip_type fadd32(input logic signed [PROD_W-1:0] a,
                                       input logic signed [PROD_W-1:0] b);
      return clip32(a + b);
   endfunction

endpackage

// File: rtl/rk4_piecewise_linear_attractor_step_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// req_      in         req_valid/req_stall req_item (command, x/y/z_init)
// rsp_      out        rsp_valid/rsp_stall rsp_item (x/y/z_out, step_count, saturated)
// csr_      in         csr_we              csr_index, csr_wdata
//
// a step item runs four slope passes on one shared 33x32 multiplier (9 products
// per pass), each pass a setup, a difference, the products and a drain; then
// the last sum, the divide by six (a load step, nine quotient digits and a
// finish step), the update and the publish, and a return to idle.
// a load item goes straight to publish. reset is synchronous and restores
// the register defaults and a zero state. a stalled result is held in the output
// register while the next item is taken; the one after that waits for it to drain.

module rk4_piecewise_linear_attractor_step_unit
   import rk4pla_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   rk4pla_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_item.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   // arithmetic and state
   rk4pla_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/rk4pla_ctrl.sv
`timescale 1ns / 1ps

module rk4pla_ctrl
   import rk4pla_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_DIFF,
      S_MUL,
      S_DRAIN,
      S_ACC,
      S_DIV_LOAD,
      S_DIV,
      S_ADV,
      S_PUBLISH
   } state_type;

   localparam logic [1:0] STAGE_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic [1:0] stage_ff, stage_in;
   mul_op_type mul_ff, mul_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take, rsp_take, slot_free;

   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer: load or four slope passes, mean, divide, update
   always_comb begin
      cmd          = '0;
      cmd.stage    = stage_ff;
      cmd.mul_op   = mul_ff;
      cmd.wb_op    = MUL_HFZ;
      state_in     = state_ff;
      stage_in     = stage_ff;
      mul_in       = mul_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd.start = 1'b1;
               if (req_command == CMD_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = S_PUBLISH;
               end else begin
                  stage_in = 2'd0;
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            mul_in   = MUL_C1D;
            state_in = S_MUL;
         end
         S_MUL: begin
            // issue one product, retire the one before it
            cmd.mul_en = 1'b1;
            if (mul_ff != MUL_C1D) begin
               cmd.wb_en = 1'b1;
               cmd.wb_op = mul_op_type'(4'(mul_ff) - 4'd1);
            end
            if (mul_ff == MUL_HFZ) begin
               state_in = S_DRAIN;
            end else begin
               mul_in = mul_op_type'(4'(mul_ff) + 4'd1);
            end
         end
         S_DRAIN: begin
            cmd.wb_en = 1'b1;
            cmd.wb_op = MUL_HFZ;
            if (stage_ff == STAGE_LAST) begin
               state_in = S_ACC;
            end else begin
               stage_in = stage_ff + 2'd1;
               state_in = S_SETUP;
            end
         end
         S_ACC: begin
            cmd.acc_last = 1'b1;
            state_in     = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in    = S_PUBLISH;
         end
         S_PUBLISH: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= 2'd0;
         mul_ff       <= MUL_C1D;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         mul_ff       <= mul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new result never overwrites one that is still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> slot_free)
      else $error("result published over a pending item");

   // update only right after the divide pass
   a_adv_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADV) |-> $past(state_ff == S_DIV))
      else $error("state update without divide pass");

   // a step item starts at the first slope stage
   a_step_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_command == CMD_STEP)) |=> (state_ff == S_SETUP && stage_ff == 2'd0))
      else $error("step item did not start at stage zero");

   // last slope pass goes on to the weighted mean
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && stage_ff == STAGE_LAST) |=> (state_ff == S_ACC))
      else $error("slope passes did not end after the fourth");

   // result valid rises only out of the publish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_PUBLISH))
      else $error("result valid rose outside publish");

endmodule

// File: rtl/rk4pla_dpath.sv
`timescale 1ns / 1ps

module rk4pla_dpath
   import rk4pla_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  req_item_type          req_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output rsp_item_type          rsp_item
);

   localparam logic signed [WORD_W-1:0] ONE_Q     = WORD_W'(64'd1 << FRAC_BITS);
   localparam logic signed [WORD_W-1:0] NEG_ONE_Q = -ONE_Q;

   // configuration registers
   logic [STEP_W-1:0]        step_ff;
   logic signed [WORD_W-1:0] c1_ff, c2_ff, c3_ff, a1_ff, a2_ff, a3_ff;

   // integrator state
   logic signed [WORD_W-1:0] pos_ff [LANES];
   logic [CNT_W-1:0]         cnt_ff;
   logic                     sat_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;

   // working registers
   logic signed [WORD_W-1:0] stg_ff [LANES];
   logic signed [WORD_W-1:0] k_ff   [LANES];
   logic signed [SUM_W-1:0]  sum_ff [LANES];
   logic [DIV_W-1:0]         div_ff [LANES];
   logic [2:0]               rem_ff [LANES];
   logic                     neg_ff [LANES];
   logic signed [WORD_W-1:0] d_ff, fx_ff, fy_ff, fz_ff;
   logic signed [PROD_W-1:0] p_ff;
   rsp_item_type             rsp_ff;

   // combinational
   logic signed [WORD_W-1:0]  half_k    [LANES];
   clip_type                  setup_clip[LANES];
   clip_type                  adv_clip  [LANES];
   logic [SUM_W-1:0]          mag       [LANES];
   logic [DIV_W-1:0]          div_t     [LANES];
   logic [2:0]                rem_t     [LANES];
   logic [3:0]                digit_t   [LANES];
   logic signed [WORD_W:0]    quot      [LANES];
   logic signed [WORD_W-1:0]  sat_x, add_b;
   clip_type                  d_clip, q_clip, add_clip;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [WORD_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      add_used, setup_hit, adv_hit, step_hit;

   assign status.div_done = (div_cnt_ff == '0);
   assign rsp_item        = rsp_ff;

   // per-lane stage state, magnitude for the divider, final update
   always_comb begin
      setup_hit = 1'b0;
      adv_hit   = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         half_k[l] = k_ff[l] >>> 1;
         if (cmd.stage == 2'd3) begin
            setup_clip[l] = fadd32(PROD_W'(pos_ff[l]), PROD_W'(k_ff[l]));
         end else begin
            setup_clip[l] = fadd32(PROD_W'(pos_ff[l]), PROD_W'(half_k[l]));
         end
         setup_hit = setup_hit | setup_clip[l].hit;
         mag[l]    = sum_ff[l][SUM_W-1] ? SUM_W'(-sum_ff[l]) : SUM_W'(sum_ff[l]);
         quot[l]   = {1'b0, div_ff[l][WORD_W-1:0]};
         if (neg_ff[l]) begin
            quot[l] = -quot[l];
         end
         adv_clip[l] = fadd32(PROD_W'(pos_ff[l]), PROD_W'(quot[l]));
         adv_hit     = adv_hit | adv_clip[l].hit;
      end
   end

   // long division by six, four quotient bits per cycle
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         div_t[l]   = div_ff[l];
         rem_t[l]   = rem_ff[l];
         digit_t[l] = '0;
         for (int j = 0; j < DIV_DIGIT; j++) begin
            digit_t[l] = {rem_t[l], div_t[l][DIV_W-1]};
            div_t[l]   = div_t[l] << 1;
            if (digit_t[l] >= MEAN_DIVISOR) begin
               rem_t[l]    = 3'(digit_t[l] - MEAN_DIVISOR);
               div_t[l][0] = 1'b1;
            end else begin
               rem_t[l] = digit_t[l][2:0];
            end
         end
      end
   end

   // distance of x beyond the unit band
   always_comb begin
      if (stg_ff[0] > ONE_Q) begin
         sat_x = ONE_Q;
      end else if (stg_ff[0] < NEG_ONE_Q) begin
         sat_x = NEG_ONE_Q;
      end else begin
         sat_x = stg_ff[0];
      end
      d_clip = clip32(PROD_W'(stg_ff[0]) - PROD_W'(sat_x));
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_op)
         MUL_C1D: begin mul_a = {c1_ff[WORD_W-1], c1_ff}; mul_b = d_ff;      end
         MUL_C2D: begin mul_a = {c2_ff[WORD_W-1], c2_ff}; mul_b = d_ff;      end
         MUL_C3D: begin mul_a = {c3_ff[WORD_W-1], c3_ff}; mul_b = d_ff;      end
         MUL_A3X: begin mul_a = {a3_ff[WORD_W-1], a3_ff}; mul_b = stg_ff[0]; end
         MUL_A2Y: begin mul_a = {a2_ff[WORD_W-1], a2_ff}; mul_b = stg_ff[1]; end
         MUL_A1Z: begin mul_a = {a1_ff[WORD_W-1], a1_ff}; mul_b = stg_ff[2]; end
         MUL_HFX: begin mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_ff}; mul_b = fx_ff; end
         MUL_HFY: begin mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_ff}; mul_b = fy_ff; end
         MUL_HFZ: begin mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_ff}; mul_b = fz_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // product scaling, the add that follows it, saturation flag
   always_comb begin
      q_clip = clip32(p_ff >>> FRAC_BITS);
      unique case (cmd.wb_op)
         MUL_C1D: begin add_b = stg_ff[1]; add_used = 1'b1; end
         MUL_C2D: begin add_b = stg_ff[2]; add_used = 1'b1; end
         MUL_A3X,
         MUL_A2Y,
         MUL_A1Z: begin add_b = fz_ff;     add_used = 1'b1; end
         default: begin add_b = '0;        add_used = 1'b0; end
      endcase
      add_clip = fadd32(PROD_W'(q_clip.value), PROD_W'(add_b));
      step_hit = (cmd.setup && (cmd.stage != 2'd0) && setup_hit) ||
                 (cmd.diff && d_clip.hit) ||
                 (cmd.wb_en && (q_clip.hit || (add_used && add_clip.hit))) ||
                 (cmd.advance && adv_hit);
   end

   // configuration, state, flag and divider count
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_SIZE_RST;
         c1_ff      <= COEF_C1_RST;
         c2_ff      <= COEF_C2_RST;
         c3_ff      <= COEF_C3_RST;
         a1_ff      <= COEF_A1_RST;
         a2_ff      <= COEF_A2_RST;
         a3_ff      <= COEF_A3_RST;
         cnt_ff     <= '0;
         sat_ff     <= 1'b0;
         div_cnt_ff <= '0;
         for (int l = 0; l < LANES; l++) begin
            pos_ff[l] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEP_SIZE: step_ff <= csr_wdata[STEP_W-1:0];
               CSR_COEF_C1:   c1_ff   <= csr_wdata;
               CSR_COEF_C2:   c2_ff   <= csr_wdata;
               CSR_COEF_C3:   c3_ff   <= csr_wdata;
               CSR_COEF_A1:   a1_ff   <= csr_wdata;
               CSR_COEF_A2:   a2_ff   <= csr_wdata;
               CSR_COEF_A3:   a3_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.start) begin
            sat_ff <= 1'b0;
         end else if (step_hit) begin
            sat_ff <= 1'b1;
         end
         if (cmd.load) begin
            pos_ff[0] <= req_item.x_init;
            pos_ff[1] <= req_item.y_init;
            pos_ff[2] <= req_item.z_init;
            cnt_ff    <= '0;
         end else if (cmd.advance) begin
            for (int l = 0; l < LANES; l++) begin
               pos_ff[l] <= adv_clip[l].value;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= DIV_CNT_W'(DIV_ITER);
         end else if (cmd.div_run && (div_cnt_ff != '0)) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p_ff <= prod;
      end
      if (cmd.diff) begin
         d_ff <= d_clip.value;
      end
      // stage state and running weighted sum
      if (cmd.setup) begin
         for (int l = 0; l < LANES; l++) begin
            unique case (cmd.stage)
               2'd0: begin
                  stg_ff[l] <= pos_ff[l];
                  sum_ff[l] <= '0;
               end
               2'd1: begin
                  stg_ff[l] <= setup_clip[l].value;
                  sum_ff[l] <= sum_ff[l] + SUM_W'(k_ff[l]);
               end
               default: begin
                  stg_ff[l] <= setup_clip[l].value;
                  sum_ff[l] <= sum_ff[l] + (SUM_W'(k_ff[l]) <<< 1);
               end
            endcase
         end
      end
      if (cmd.acc_last) begin
         for (int l = 0; l < LANES; l++) begin
            sum_ff[l] <= sum_ff[l] + SUM_W'(k_ff[l]);
         end
      end
      // product retire
      if (cmd.wb_en) begin
         unique case (cmd.wb_op)
            MUL_C1D: fx_ff   <= add_clip.value;
            MUL_C2D: fy_ff   <= add_clip.value;
            MUL_C3D: fz_ff   <= q_clip.value;
            MUL_A3X,
            MUL_A2Y,
            MUL_A1Z: fz_ff   <= add_clip.value;
            MUL_HFX: k_ff[0] <= q_clip.value;
            MUL_HFY: k_ff[1] <= q_clip.value;
            MUL_HFZ: k_ff[2] <= q_clip.value;
            default: ;
         endcase
      end
      // divider lanes
      for (int l = 0; l < LANES; l++) begin
         if (cmd.div_start) begin
            div_ff[l] <= DIV_W'(mag[l]);
            rem_ff[l] <= '0;
            neg_ff[l] <= sum_ff[l][SUM_W-1];
         end else if (cmd.div_run && (div_cnt_ff != '0)) begin
            div_ff[l] <= div_t[l];
            rem_ff[l] <= rem_t[l];
         end
      end
      if (cmd.publish) begin
         rsp_ff.x_out      <= pos_ff[0];
         rsp_ff.y_out      <= pos_ff[1];
         rsp_ff.z_out      <= pos_ff[2];
         rsp_ff.step_count <= cnt_ff;
         rsp_ff.saturated  <= sat_ff;
      end
   end

endmodule
